### hdl/pmh_pkg.sv
`default_nettype none
package pmh_pkg;

	localparam int LEVEL_BITS     = 20;
	localparam int CHUNK_BITS     = 16;
	localparam int HOLD_BITS      = 9;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_CHUNK_SIZE  = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_CHUNKS = 1'd1;

	localparam logic [CHUNK_BITS-1:0] CHUNK_SIZE_RESET  = 16'd480;
	localparam int                    HOLD_CHUNKS_RESET = 100;

	// Controls for the compare unit.
	typedef struct packed {
		logic init;
		logic take;
	} pmh_acc_ctl_t;

endpackage
`default_nettype wire

### hdl/pmh_ram.sv
`default_nettype none
module pmh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [ADDR_BITS-1:0]     waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [ADDR_BITS-1:0]     raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### hdl/pmh_maxunit.sv
`default_nettype none
module pmh_maxunit import pmh_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_CHUNKS  = 256,
	localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
	localparam int HW = $clog2(MAX_CHUNKS + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pmh_acc_ctl_t                  ctl,
	input  wire logic [AW-1:0]                 idx,
	input  wire logic [AW-1:0]                 start,
	input  wire logic [HW-1:0]                 hold,
	input  wire logic [HW-1:0]                 fill,
	input  wire logic signed [SAMPLE_BITS-1:0] data,
	output logic signed [SAMPLE_BITS-1:0]      best
);

	localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic [HW-1:0] offset;
	logic          entry_ok;

	// A slot holds a written peak when its distance from the first slot written
	// since the last clear, taken round the window, is below the fill count.
	always_comb begin
		if (HW'(idx) >= HW'(start)) begin
			offset = HW'(idx) - HW'(start);
		end else begin
			offset = HW'(idx) + hold - HW'(start);
		end
		entry_ok = offset < fill;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best <= MOST_NEG;
		end else if (ctl.init) begin
			best <= MOST_NEG;
		end else if (ctl.take && entry_ok && (data > best)) begin
			best <= data;
		end
	end

endmodule
`default_nettype wire

### hdl/peak_meter_with_hold.sv
// A sample that does not end a chunk is folded into the running peak and gives no
// result. A sample that ends a chunk gives its level after a ring write, a read of
// each slot in the hold window, a read drain and an output load, which waits while
// the output is stalled. No sample is taken meanwhile. Reset is asynchronous and
// active low; the ring needs no clearing pass, since a fill count marks which
// slots have been written since the last clear.
`default_nettype none
module peak_meter_with_hold import pmh_pkg::*; #(
	parameter int MAX_CHUNKS  = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [LEVEL_BITS-1:0]       level,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

	localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int HW = $clog2(MAX_CHUNKS + 1);
	localparam int PW = (SAMPLE_BITS + 4 > LEVEL_BITS) ? SAMPLE_BITS + 4 : LEVEL_BITS;
	localparam int HOLD_INIT = (HOLD_CHUNKS_RESET > MAX_CHUNKS) ? MAX_CHUNKS
		: HOLD_CHUNKS_RESET;

	localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WR    = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]                    state_q;
	logic [CHUNK_BITS-1:0]         chunk_size_q;
	logic [HW-1:0]                 hold_q;
	logic signed [SAMPLE_BITS-1:0] peak_q;
	logic signed [SAMPLE_BITS-1:0] store_q;
	logic [CHUNK_BITS-1:0]         left_q;
	logic [AW-1:0]                 slot_q;
	logic [AW-1:0]                 start_q;
	logic [HW-1:0]                 fill_q;
	logic [AW-1:0]                 idx_q;
	logic                          rd_v_s1;
	logic [AW-1:0]                 rd_idx_s1;
	logic                          out_valid_q;
	logic signed [LEVEL_BITS-1:0]  level_q;

	logic                          in_acc;
	logic                          cfg_acc;
	logic                          out_free;
	logic signed [SAMPLE_BITS-1:0] folded;
	logic [CHUNK_BITS-1:0]         reload;
	logic [HW-1:0]                 slot_next;
	logic [31:0]                   hold_sat;
	logic [HW-1:0]                 hold_new;
	logic signed [SAMPLE_BITS-1:0] rd_data;
	logic signed [SAMPLE_BITS-1:0] best;
	logic signed [PW-1:0]          best_ext;
	logic signed [PW-1:0]          times_ten;
	pmh_acc_ctl_t                  acc_ctl;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign level     = level_q;

	assign in_acc   = in_valid && !in_stall;
	assign cfg_acc  = cfg_valid && cfg_ready;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		folded = (sample > peak_q) ? sample : peak_q;
		reload = (chunk_size_q == '0) ? '0 : chunk_size_q - 1'b1;
		slot_next = HW'(slot_q) + 1'b1;
		if (slot_next >= hold_q) begin
			slot_next = '0;
		end
		hold_sat = 32'(cfg_data[HOLD_BITS-1:0]);
		if (hold_sat == 32'd0) begin
			hold_sat = 32'd1;
		end
		if (hold_sat > 32'(MAX_CHUNKS)) begin
			hold_sat = 32'(MAX_CHUNKS);
		end
		hold_new  = hold_sat[HW-1:0];
		best_ext  = {{(PW-SAMPLE_BITS){best[SAMPLE_BITS-1]}}, best};
		times_ten = (best_ext <<< 3) + (best_ext <<< 1);
		acc_ctl.init = (state_q == ST_WR);
		acc_ctl.take = rd_v_s1;
	end

	pmh_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_CHUNKS)
	) u_ring (
		.clk   (clk),
		.we    (state_q == ST_WR),
		.waddr (slot_q),
		.wdata (store_q),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	pmh_maxunit #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_CHUNKS  (MAX_CHUNKS)
	) u_max (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.idx    (rd_idx_s1),
		.start  (start_q),
		.hold   (hold_q),
		.fill   (fill_q),
		.data   (rd_data),
		.best   (best)
	);

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (in_acc && (left_q == '0)) begin
			store_q <= folded;
		end
		if ((state_q == ST_OUT) && out_free) begin
			level_q <= times_ten[LEVEL_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			chunk_size_q <= CHUNK_SIZE_RESET;
			hold_q       <= HW'(HOLD_INIT);
			peak_q       <= MOST_NEG;
			left_q       <= '0;
			slot_q       <= '0;
			start_q      <= '0;
			fill_q       <= '0;
			idx_q        <= '0;
			rd_v_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_SCAN);
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (left_q == '0) begin
							peak_q  <= sample;
							left_q  <= reload;
							state_q <= ST_WR;
						end else begin
							peak_q <= folded;
							left_q <= left_q - 1'b1;
						end
					end
					if (cfg_acc) begin
						case (cfg_index)
							REG_CHUNK_SIZE: begin
								chunk_size_q <= cfg_data[CHUNK_BITS-1:0];
							end
							REG_HOLD_CHUNKS: begin
								hold_q <= hold_new;
								fill_q <= '0;
								if (HW'(slot_q) >= hold_new) begin
									slot_q  <= '0;
									start_q <= '0;
								end else begin
									start_q <= slot_q;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_WR: begin
					slot_q <= slot_next[AW-1:0];
					if (fill_q != hold_q) begin
						fill_q <= fill_q + 1'b1;
					end
					idx_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (HW'(idx_q) == hold_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The fill count never exceeds the window, and the write slot stays inside it.
	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= hold_q) && (HW'(slot_q) < hold_q))
		else $error("fill count or write slot outside the hold window");

	// Every returned read belongs to a slot inside the hold window.
	a_read_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (HW'(rd_idx_s1) < hold_q))
		else $error("ring read beyond the hold window");

	// A ring write is always followed by a scan from the first slot.
	a_scan_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |=> ((state_q == ST_SCAN) && (idx_q == '0)))
		else $error("scan did not start at slot zero after a ring write");

	// A sample inside a chunk leaves the block free for the next one.
	a_mid_chunk_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (left_q != '0)) |=> (state_q == ST_IDLE))
		else $error("mid-chunk sample started a scan");

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top import pmh_pkg::*;;
	localparam int MAX_CHUNKS  = 256;
	localparam int SAMPLE_BITS = 16;
	localparam int SETTLE      = MAX_CHUNKS + 8;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int MOST_NEG    = -(1 << (SAMPLE_BITS - 1));

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SAMPLE_BITS-1:0] sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [LEVEL_BITS-1:0] level;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_CHUNK_SIZE;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	peak_meter_with_hold #(
		.MAX_CHUNKS(MAX_CHUNKS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.level(level),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Meter state as the block should hold it.
	int chunk_len;
	int hold_len;
	int peak_acc;
	int slots_to_go;
	int chunk_peaks[MAX_CHUNKS];
	int next_slot;

	logic signed [SAMPLE_BITS-1:0] pending_samples[$];
	logic signed [LEVEL_BITS-1:0] expected_levels[$];

	int pushed_items = 0;
	int taken_items = 0;
	int levels_seen = 0;
	int reg_writes = 0;
	int fails = 0;
	int cycles = 0;
	int idle_pct = 0;
	bit pressure_on = 1'b0;
	bit pressure_done = 1'b0;
	int gap_left = 0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void clear_peaks();
		for (int i = 0; i < MAX_CHUNKS; i++)
			chunk_peaks[i] = MOST_NEG;
	endfunction

	function automatic void meter_reset();
		chunk_len = CHUNK_SIZE_RESET;
		hold_len = HOLD_CHUNKS_RESET;
		peak_acc = MOST_NEG;
		slots_to_go = 0;
		next_slot = 0;
		clear_peaks();
	endfunction

	function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		int n;
		if (idx == REG_CHUNK_SIZE) begin
			chunk_len = val;
		end else if (idx == REG_HOLD_CHUNKS) begin
			n = val[HOLD_BITS-1:0];
			if (n < 1)
				n = 1;
			if (n > MAX_CHUNKS)
				n = MAX_CHUNKS;
			hold_len = n;
			clear_peaks();
			if (next_slot >= hold_len)
				next_slot = 0;
		end
	endfunction

	// Folds one sample into the meter; returns 1 when it closes a chunk.
	function automatic bit meter_step(input logic signed [SAMPLE_BITS-1:0] s,
			output logic signed [LEVEL_BITS-1:0] lvl);
		int best;
		bit closed;
		closed = 1'b0;
		lvl = '0;
		if (slots_to_go == 0) begin
			if (s > peak_acc)
				peak_acc = s;
			if (next_slot >= hold_len)
				next_slot = 0;
			chunk_peaks[next_slot] = peak_acc;
			peak_acc = MOST_NEG;
			next_slot++;
			if (next_slot >= hold_len)
				next_slot = 0;
			slots_to_go = (chunk_len == 0) ? 0 : chunk_len - 1;
			best = chunk_peaks[0];
			for (int i = 1; i < hold_len; i++)
				if (chunk_peaks[i] > best)
					best = chunk_peaks[i];
			lvl = LEVEL_BITS'(best * 10);
			closed = 1'b1;
		end else begin
			slots_to_go--;
		end
		if (s > peak_acc)
			peak_acc = s;
		return closed;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2, 3: return 16'($urandom_range(0, 511)) - 16'd256;
			4: return -16'($urandom_range(1, 32768));
			default: return $signed(16'($urandom)) >>> $urandom_range(0, 14);
		endcase
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
				gap_left = $urandom_range(1, 7);
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				sample <= pending_samples.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		logic signed [LEVEL_BITS-1:0] lvl;
		if (arst_n && in_valid && !in_stall) begin
			taken_items++;
			if (meter_step(sample, lvl))
				expected_levels.push_back(lvl);
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			apply_reg(cfg_index, cfg_data);
			reg_writes++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (pressure_on && !pressure_done) begin
			pressure_done = 1'b1;
			hold_left = 600;
			out_stall <= 1'b1;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			hold_left = $urandom_range(0, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		logic signed [LEVEL_BITS-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_levels.size() == 0) begin
				$error("level: no item expected, actual %0d", level);
				fails++;
			end else begin
				want = expected_levels.pop_front();
				levels_seen++;
				if (level !== want) begin
					$error("level: expected %0d, actual %0d", want, level);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("peak_meter_with_hold verification failed");
			$finish;
		end
	end

	task automatic offer(input logic signed [SAMPLE_BITS-1:0] s);
		pending_samples.push_back(s);
		pushed_items++;
	endtask

	task automatic wait_idle();
		while (taken_items != pushed_items || expected_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [CFG_DATA_BITS-1:0] chunk_v,
			input logic [CFG_DATA_BITS-1:0] hold_v, input int n, input int idle_v,
			input bit squeeze);
		wait_idle();
		write_reg(REG_CHUNK_SIZE, chunk_v);
		write_reg(REG_HOLD_CHUNKS, hold_v);
		idle_pct <= idle_v;
		pressure_on <= squeeze;
		repeat (n)
			offer(pick_sample());
	endtask

	initial begin
		meter_reset();
		idle_pct <= 25;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The very first sample closes a chunk against a cleared ring.
		offer(16'sh8000);
		offer(16'sh7FFF);
		offer(16'sh0000);
		offer(-16'sd1);
		// A chunk size of zero behaves as one sample per chunk.
		wait_idle();
		write_reg(REG_CHUNK_SIZE, 16'd0);
		offer(16'sd100);
		offer(-16'sd5);
		offer(16'sh7FFF);
		// A hold count of zero saturates to one slot.
		wait_idle();
		write_reg(REG_HOLD_CHUNKS, 16'd0);
		offer(16'sh8000);
		offer(16'sd5);
		offer(16'sh8000);
		// Only the low bits count, and the result saturates to the full ring.
		wait_idle();
		write_reg(REG_HOLD_CHUNKS, 16'hFFFF);
		offer(16'sh7FFF);
		offer(-16'sd2);
		wait_idle();
		write_reg(REG_HOLD_CHUNKS, 16'd256);
		write_reg(REG_CHUNK_SIZE, 16'd1);
		offer(16'sh8000);
		offer(16'sd1);
		offer(16'sh5555);
		offer(-16'sh2AAB);

		run_phase(16'd1, 16'd1, 120, 20, 1'b0);
		run_phase(16'd3, 16'd7, 200, 25, 1'b0);
		run_phase(16'd2, 16'd257, 100, 20, 1'b0);
		run_phase(16'd1, 16'd4, 150, 10, 1'b1);
		run_phase(16'd5, 16'd12, 200, 0, 1'b0);
		run_phase(16'd0, 16'hFE21, 120, 30, 1'b0);
		run_phase(16'd8, 16'd2, 200, 25, 1'b0);
		run_phase(16'd4, 16'd3, 150, 0, 1'b0);
		run_phase(16'hFFFF, 16'd5, 30, 0, 1'b0);

		wait_idle();
		$display("Took %0d samples and checked %0d levels over %0d register writes,",
			taken_items, levels_seen, reg_writes);
		$display("including a long output hold-off that backed up the input.");
		if (fails == 0 && expected_levels.size() == 0)
			$display("peak_meter_with_hold verification clean");
		else
			$display("peak_meter_with_hold verification failed");
		$finish;
	end
endmodule
